>>> sv/kuz_pkg.sv
// ----------------------------------------------------------------------------
// Kuznyechik cipher package
// Types, S-box tables and GF(2^8) linear-layer functions.
// ----------------------------------------------------------------------------
package kuz_pkg;

    typedef logic [7:0] byte_tab_t [256];
    typedef logic [7:0] coef_tab_t [16];

    localparam int unsigned RK_COUNT = 10;
    localparam int unsigned L_STEPS  = 4;
    localparam int unsigned FEISTEL_STEPS = 32;
    localparam logic [7:0] GF_REDUCE = 8'hC3;

    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD3 = 2'd0,
        REG_KEY_WORD2 = 2'd1,
        REG_KEY_WORD1 = 2'd2,
        REG_KEY_WORD0 = 2'd3
    } cfg_reg_t;

    localparam byte_tab_t SBOX = '{
        252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
        233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
        249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
        5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
        235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
        181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
        21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
        50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
        223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
        224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
        167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
        173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
        7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
        225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
        32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
        89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
    };

    localparam coef_tab_t LIN_COEF = '{
        1,148,32,133,16,194,192,1,251,1,192,194,16,133,32,148
    };

    function automatic byte_tab_t build_inv();
        byte_tab_t t;
        for (int v = 0; v < 256; v++) begin
            t[SBOX[v]] = 8'(v);
        end
        return t;
    endfunction

    localparam byte_tab_t SBOX_INV = build_inv();

    function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
        logic [7:0] z;
        logic [7:0] a;
        z = 8'h00;
        a = x;
        for (int n = 0; n < 8; n++) begin
            if (y[n]) begin
                z = z ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
        end
        return z;
    endfunction

    function automatic logic [127:0] lin_step_fwd(logic [127:0] v);
        logic [7:0] z;
        z = v[7:0];
        for (int i = 1; i < 16; i++) begin
            z = z ^ gf_mul(v[8*i +: 8], LIN_COEF[i]);
        end
        return {z, v[127:8]};
    endfunction

    function automatic logic [127:0] lin_step_inv(logic [127:0] v);
        logic [7:0] z;
        z = v[127:120];
        for (int i = 1; i < 16; i++) begin
            z = z ^ gf_mul(v[8*(i-1) +: 8], LIN_COEF[i]);
        end
        return {v[119:0], z};
    endfunction

    function automatic logic [127:0] lin_part_fwd(logic [127:0] v);
        logic [127:0] r;
        r = v;
        for (int s = 0; s < L_STEPS; s++) begin
            r = lin_step_fwd(r);
        end
        return r;
    endfunction

    function automatic logic [127:0] lin_part_inv(logic [127:0] v);
        logic [127:0] r;
        r = v;
        for (int s = 0; s < L_STEPS; s++) begin
            r = lin_step_inv(r);
        end
        return r;
    endfunction

    function automatic logic [127:0] sub_fwd(logic [127:0] v);
        logic [127:0] r;
        for (int n = 0; n < 16; n++) begin
            r[8*n +: 8] = SBOX[v[8*n +: 8]];
        end
        return r;
    endfunction

    function automatic logic [127:0] sub_inv(logic [127:0] v);
        logic [127:0] r;
        for (int n = 0; n < 16; n++) begin
            r[8*n +: 8] = SBOX_INV[v[8*n +: 8]];
        end
        return r;
    endfunction

endpackage

>>> sv/kuz_if.sv
// ----------------------------------------------------------------------------
// Kuznyechik channel interfaces
// Block input, result output and key configuration channels.
// ----------------------------------------------------------------------------
interface kuz_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, cmd, block_high, block_low, input ready);
    modport sink   (input valid, cmd, block_high, block_low, output ready);
endinterface

interface kuz_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface kuz_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kuz_pkg::CFG_IDX_W-1:0]  index;
    logic [63:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/kuz_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kuz_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/kuznyechik_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// Kuznyechik block cipher unit
// 128-bit block, 256-bit key; round keys expanded into two 64-bit RAMs.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  blk_in    in   cmd (0 enc, 1 dec), block_high, block_low
//  blk_out   out  result_high, result_low
//  cfg       in   index (key word), data
//
//  Encrypt and decrypt run a round loop from accept to result: each round
//  has an S/key state and the linear layer (four LFSR steps per
//  cycle), with round keys read ahead from the registered key RAMs.
//  A new beat is taken only in IDLE, once the last result has registered.
//  Key expansion runs after reset and after every key write: 32 Feistel
//  steps with 10 round-key writes, blk_in stalled.
//  A finished result waits in the output register; the core holds in its
//  final round until that register is free.
// ----------------------------------------------------------------------------
module kuznyechik_block_cipher_unit (
    input  logic             clk,
    input  logic             rst_n,
    kuz_in_if.sink           blk_in,
    kuz_out_if.source        blk_out,
    kuz_cfg_if.sink          cfg
);

    localparam int unsigned ADDR_W = $clog2(kuz_pkg::RK_COUNT);
    localparam int unsigned IDX_W  = $clog2(kuz_pkg::FEISTEL_STEPS + 1);
    localparam int unsigned LC_W   = $clog2(kuz_pkg::L_STEPS);

    typedef enum logic [16:0] {
        K_INIT = 17'h00001,
        K_WR0  = 17'h00002,
        K_CON  = 17'h00004,
        K_CLIN = 17'h00008,
        K_SUB  = 17'h00010,
        K_TLIN = 17'h00020,
        K_UPD  = 17'h00040,
        K_WRA  = 17'h00080,
        K_WRB  = 17'h00100,
        IDLE   = 17'h00200,
        WAIT   = 17'h00400,
        E_SUB  = 17'h00800,
        E_LIN  = 17'h01000,
        E_FIN  = 17'h02000,
        D_XOR  = 17'h04000,
        D_LIN  = 17'h08000,
        D_SUB  = 17'h10000
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [63:0]       key3_reg, key2_reg, key1_reg, key0_reg;
    logic [127:0]      a1_reg, a1_next, a0_reg, a0_next;
    logic [127:0]      kx_reg, kx_next;
    logic [127:0]      st_reg, st_next;
    logic [127:0]      res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic              dec_reg, dec_next;
    logic [ADDR_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [LC_W-1:0]   lcnt_reg, lcnt_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [127:0]      ram_wdata;
    logic [127:0]      rk;
    logic [127:0]      lin_src;
    logic [127:0]      lin_f;
    logic [127:0]      lin_i;
    logic [127:0]      dsub_val;
    logic              out_free;
    logic              lin_last;
    logic              cfg_write;

    kuz_ram #(.WIDTH(64), .DEPTH(kuz_pkg::RK_COUNT)) u_ram_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata[127:64]),
        .raddr (round_reg),
        .rdata (rk[127:64])
    );

    kuz_ram #(.WIDTH(64), .DEPTH(kuz_pkg::RK_COUNT)) u_ram_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata[63:0]),
        .raddr (round_reg),
        .rdata (rk[63:0])
    );

    assign cfg.ready           = 1'b1;
    assign cfg_write           = cfg.valid;
    assign blk_in.ready        = (state_reg == IDLE) && !cfg.valid;
    assign blk_out.valid       = out_valid_reg;
    assign blk_out.result_high = res_reg[127:64];
    assign blk_out.result_low  = res_reg[63:0];

    assign out_free = !out_valid_reg || blk_out.ready;
    assign lin_last = (lcnt_reg == LC_W'(kuz_pkg::L_STEPS - 1));
    assign lin_src  = (state_reg == K_CLIN || state_reg == K_TLIN) ? kx_reg : st_reg;
    assign lin_f    = kuz_pkg::lin_part_fwd(lin_src);
    assign lin_i    = kuz_pkg::lin_part_inv(st_reg);
    assign dsub_val = kuz_pkg::sub_inv(st_reg) ^ rk;

    always_comb
    begin
        state_next     = state_reg;
        a1_next        = a1_reg;
        a0_next        = a0_reg;
        kx_next        = kx_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        dec_next       = dec_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        lcnt_next      = lcnt_reg;
        out_valid_next = out_valid_reg && !blk_out.ready;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = a1_reg;

        case (state_reg)
            K_INIT:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {key3_reg, key2_reg};
                a1_next    = {key3_reg, key2_reg};
                a0_next    = {key1_reg, key0_reg};
                state_next = K_WR0;
            end
            K_WR0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(1);
                ram_wdata  = a0_reg;
                idx_next   = IDX_W'(1);
                state_next = K_CON;
            end
            K_CON:
            begin
                kx_next    = 128'(idx_reg);
                lcnt_next  = '0;
                state_next = K_CLIN;
            end
            K_CLIN:
            begin
                kx_next   = lin_f;
                lcnt_next = lcnt_reg + 1'b1;
                if (lin_last)
                begin
                    state_next = K_SUB;
                end
            end
            K_SUB:
            begin
                kx_next    = kuz_pkg::sub_fwd(a1_reg ^ kx_reg);
                state_next = K_TLIN;
            end
            K_TLIN:
            begin
                kx_next   = lin_f;
                lcnt_next = lcnt_reg + 1'b1;
                if (lin_last)
                begin
                    state_next = K_UPD;
                end
            end
            K_UPD:
            begin
                a1_next = kx_reg ^ a0_reg;
                a0_next = a1_reg;
                if (idx_reg[2:0] == 3'd0)
                begin
                    state_next = K_WRA;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = K_CON;
                end
            end
            K_WRA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'({idx_reg[IDX_W-1:3], 1'b0});
                ram_wdata  = a1_reg;
                state_next = K_WRB;
            end
            K_WRB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'({idx_reg[IDX_W-1:3], 1'b1});
                ram_wdata  = a0_reg;
                if (idx_reg == IDX_W'(kuz_pkg::FEISTEL_STEPS))
                begin
                    state_next = IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = K_CON;
                end
            end
            IDLE:
            begin
                if (blk_in.valid)
                begin
                    st_next    = {blk_in.block_high, blk_in.block_low};
                    dec_next   = blk_in.cmd;
                    round_next = blk_in.cmd ? ADDR_W'(kuz_pkg::RK_COUNT - 1) : '0;
                    state_next = WAIT;
                end
            end
            WAIT:
            begin
                state_next = dec_reg ? D_XOR : E_SUB;
            end
            E_SUB:
            begin
                st_next    = kuz_pkg::sub_fwd(st_reg ^ rk);
                round_next = round_reg + 1'b1;
                lcnt_next  = '0;
                state_next = E_LIN;
            end
            E_LIN:
            begin
                st_next   = lin_f;
                lcnt_next = lcnt_reg + 1'b1;
                if (lin_last)
                begin
                    state_next = (round_reg == ADDR_W'(kuz_pkg::RK_COUNT - 1)) ? E_FIN : E_SUB;
                end
            end
            E_FIN:
            begin
                if (out_free)
                begin
                    res_next       = st_reg ^ rk;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            D_XOR:
            begin
                st_next    = st_reg ^ rk;
                round_next = round_reg - 1'b1;
                lcnt_next  = '0;
                state_next = D_LIN;
            end
            D_LIN:
            begin
                st_next   = lin_i;
                lcnt_next = lcnt_reg + 1'b1;
                if (lin_last)
                begin
                    state_next = D_SUB;
                end
            end
            D_SUB:
            begin
                if (round_reg == '0)
                begin
                    if (out_free)
                    begin
                        res_next       = dsub_val;
                        out_valid_next = 1'b1;
                        state_next     = IDLE;
                    end
                end
                else
                begin
                    st_next    = dsub_val;
                    round_next = round_reg - 1'b1;
                    lcnt_next  = '0;
                    state_next = D_LIN;
                end
            end
            default:
            begin
                state_next = K_INIT;
            end
        endcase

        if (cfg_write)
        begin
            state_next = K_INIT;
            lcnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= K_INIT;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
            idx_reg       <= '0;
            lcnt_reg      <= '0;
            dec_reg       <= 1'b0;
            key3_reg      <= '0;
            key2_reg      <= '0;
            key1_reg      <= '0;
            key0_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            lcnt_reg      <= lcnt_next;
            dec_reg       <= dec_next;
            if (cfg_write)
            begin
                case (kuz_pkg::cfg_reg_t'(cfg.index))
                    kuz_pkg::REG_KEY_WORD3: key3_reg <= cfg.data;
                    kuz_pkg::REG_KEY_WORD2: key2_reg <= cfg.data;
                    kuz_pkg::REG_KEY_WORD1: key1_reg <= cfg.data;
                    kuz_pkg::REG_KEY_WORD0: key0_reg <= cfg.data;
                    default: key0_reg <= key0_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg  <= a1_next;
        a0_reg  <= a0_next;
        kx_reg  <= kx_next;
        st_reg  <= st_next;
        res_reg <= res_next;
    end

endmodule

>>> verif/kuznyechik_block_cipher_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kuznyechik block cipher unit testbench
// Drives encrypt and decrypt beats under several 256-bit keys, with random
// stalls on both channels, and checks every result against a behavioral
// cipher model held in a small scoreboard.
// ----------------------------------------------------------------------------
class cipher_scoreboard;
    logic [63:0]  key_w[4];
    logic [127:0] rk[10];
    logic [127:0] pending[$];
    int           errors;

    function new();
        errors = 0;
        foreach (key_w[i]) key_w[i] = '0;
        expand();
    endfunction

    function logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
        logic [7:0] z;
        z = 0;
        for (int n = 0; n < 8; n++) begin
            if (y[n]) z ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
        end
        return z;
    endfunction

    function logic [127:0] lmix(logic [127:0] v);
        logic [7:0] z;
        for (int s = 0; s < 16; s++) begin
            z = v[7:0];
            for (int i = 1; i < 16; i++) z ^= gmul(v[8*i +: 8], kuz_pkg::LIN_COEF[i]);
            v = {z, v[127:8]};
        end
        return v;
    endfunction

    function logic [127:0] lunmix(logic [127:0] v);
        logic [7:0] z;
        for (int s = 0; s < 16; s++) begin
            z = v[127:120];
            for (int i = 1; i < 16; i++)
                z ^= gmul(v[8*(i-1) +: 8], kuz_pkg::LIN_COEF[i]);
            v = {v[119:0], z};
        end
        return v;
    endfunction

    function logic [127:0] subst(logic [127:0] v, bit inv);
        logic [127:0] r;
        for (int n = 0; n < 16; n++)
            r[8*n +: 8] = inv ? kuz_pkg::SBOX_INV[v[8*n +: 8]] : kuz_pkg::SBOX[v[8*n +: 8]];
        return r;
    endfunction

    function void expand();
        logic [127:0] a1, a0, c, t;
        int idx;
        a1 = {key_w[0], key_w[1]};
        a0 = {key_w[2], key_w[3]};
        rk[0] = a1;
        rk[1] = a0;
        idx = 0;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 8; i++) begin
                idx++;
                c = lmix(128'(idx));
                t = lmix(subst(a1 ^ c, 0)) ^ a0;
                a0 = a1;
                a1 = t;
            end
            rk[2*j+2] = a1;
            rk[2*j+3] = a0;
        end
    endfunction

    function void set_key(kuz_pkg::cfg_reg_t r, logic [63:0] d);
        key_w[r] = d;
        expand();
    endfunction

    function void note_block(bit dec, logic [127:0] b);
        if (!dec) begin
            for (int r = 0; r < 9; r++) b = lmix(subst(b ^ rk[r], 0));
            b ^= rk[9];
        end else begin
            b ^= rk[9];
            for (int r = 9; r >= 1; r--) b = subst(lunmix(b), 1) ^ rk[r-1];
        end
        pending.push_back(b);
    endfunction

    function void check_result(logic [127:0] got);
        logic [127:0] exp_b;
        if (pending.size() == 0) begin
            report("unexpected result", got, 'x);
            return;
        end
        exp_b = pending.pop_front();
        if (got[127:64] !== exp_b[127:64]) report("result_high", got, exp_b);
        if (got[63:0] !== exp_b[63:0]) report("result_low", got, exp_b);
    endfunction

    function void report(string what, logic [127:0] got, logic [127:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h", what, got, want);
    endfunction
endclass

module kuznyechik_block_cipher_unit_tb;
    logic clk;
    logic rst_n;
    kuz_in_if  blk_in ();
    kuz_out_if blk_out ();
    kuz_cfg_if cfg ();

    cipher_scoreboard sb;
    bit     calm;
    bit     hold_out;
    longint cycles;

    kuznyechik_block_cipher_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .blk_in  (blk_in.sink),
        .blk_out (blk_out.source),
        .cfg     (cfg.sink)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && blk_in.valid && blk_in.ready)
            sb.note_block(blk_in.cmd, {blk_in.block_high, blk_in.block_low});
        if (rst_n && blk_out.valid && blk_out.ready)
            sb.check_result({blk_out.result_high, blk_out.result_low});
    end

    initial begin
        blk_out.ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_out) blk_out.ready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0) begin
                blk_out.ready <= 0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                blk_out.ready <= 1;
            end else blk_out.ready <= 1;
        end
    end

    task automatic send_block(bit dec, logic [63:0] hi, logic [63:0] lo);
        if (!calm && $urandom_range(0, 4) == 0) begin
            blk_in.valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        blk_in.valid <= 1;
        blk_in.cmd <= dec;
        blk_in.block_high <= hi;
        blk_in.block_low <= lo;
        while (!blk_in.ready) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        blk_in.valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_key(logic [63:0] w3, logic [63:0] w2,
                             logic [63:0] w1, logic [63:0] w0);
        logic [63:0]        words[4];
        kuz_pkg::cfg_reg_t  reg_idx;
        words = '{w3, w2, w1, w0};
        for (int r = 0; r < 4; r++) begin
            reg_idx = kuz_pkg::cfg_reg_t'(r[1:0]);
            cfg.valid <= 1;
            cfg.index <= reg_idx;
            cfg.data <= words[r];
            while (!cfg.ready) @(negedge clk);
            @(posedge clk);
            sb.set_key(reg_idx, words[r]);
            @(negedge clk);
        end
        cfg.valid <= 0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_blocks(int n);
        logic [63:0] hi, lo;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: begin hi = '0; lo = '0; end
                1: begin hi = '1; lo = '1; end
                default: begin hi = rnd64(); lo = rnd64(); end
            endcase
            send_block($urandom_range(0, 1), hi, lo);
        end
    endtask

    initial begin
        sb = new();
        calm = 0;
        hold_out = 0;
        rst_n = 0;
        blk_in.valid = 0;
        blk_in.cmd = 0;
        blk_in.block_high = 0;
        blk_in.block_low = 0;
        cfg.valid = 0;
        cfg.index = kuz_pkg::REG_KEY_WORD3;
        cfg.data = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // all-zero key from reset
        send_block(0, '0, '0);
        send_block(1, '0, '0);
        send_block(0, '1, '1);
        send_block(1, '1, '1);
        drain();

        // standard test key and vector
        write_key(64'h8899aabbccddeeff, 64'h0011223344556677,
                  64'hfedcba9876543210, 64'h0123456789abcdef);
        send_block(0, 64'h1122334455667700, 64'hffeeddccbbaa9988);
        send_block(1, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd);
        send_block(0, 64'h8000000000000000, 64'h0000000000000001);
        send_block(1, 64'h8000000000000000, 64'h0000000000000001);
        drain();

        // all-ones key
        write_key('1, '1, '1, '1);
        send_block(0, '0, '1);
        send_block(1, '1, '0);
        random_blocks(200);
        drain();

        // long output stall holds a result in the output register and stalls blk_in
        hold_out = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_out = 0;
            end
            random_blocks(30);
        join
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_key(rnd64(), rnd64(), rnd64(), rnd64());
            random_blocks(200);
            drain();
        end

        calm = 1;
        random_blocks(200);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
sv/kuz_pkg.sv
sv/kuz_if.sv
sv/kuz_ram.sv
sv/kuznyechik_block_cipher_unit.sv
verif/kuznyechik_block_cipher_unit_tb.sv
